FILE: hw/rtl/bds_pkg.sv
// shared constants and types of the 2x2 rgb box downsampler
// no dependencies; used by every other file of the block except bds_ram

package bds_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SLOT_W     = $clog2(LINE_DEPTH);
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int CHAN_W     = 8;
	localparam int PAIR_W     = CHAN_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// per-channel horizontal pair sums, also the line store word
	typedef struct packed {
		logic [PAIR_W-1:0] r;
		logic [PAIR_W-1:0] g;
		logic [PAIR_W-1:0] b;
	} pair_t;

	localparam int PAIR_BITS = $bits(pair_t);

	// frame geometry derived from the configuration registers
	typedef struct packed {
		logic [COL_W-1:0]    col_wrap;
		logic [HEIGHT_W-1:0] row_wrap;
		logic [COL_W-1:0]    col_last;
		logic [HEIGHT_W-1:0] row_last;
	} geom_t;

	// what one accepted pixel produces
	typedef struct packed {
		logic  produce;
		logic  frame_end;
		pair_t pair;
	} step_t;

endpackage

FILE: hw/rtl/bds_pix_in_if.sv
// input pixel channel: valid/ready with one rgb pixel
// depends on bds_pkg

interface bds_pix_in_if;
	logic                       valid;
	logic                       ready;
	logic [bds_pkg::CHAN_W-1:0] red_in;
	logic [bds_pkg::CHAN_W-1:0] green_in;
	logic [bds_pkg::CHAN_W-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

FILE: hw/rtl/bds_pix_out_if.sv
// output pixel channel: valid/ready with one averaged rgb pixel and frame end flag
// depends on bds_pkg

interface bds_pix_out_if;
	logic                       valid;
	logic                       ready;
	logic [bds_pkg::CHAN_W-1:0] red_out;
	logic [bds_pkg::CHAN_W-1:0] green_out;
	logic [bds_pkg::CHAN_W-1:0] blue_out;
	logic                       frame_end;

	modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

FILE: hw/rtl/bds_cfg_if.sv
// configuration write channel: valid/ready with register index and data
// depends on bds_pkg

interface bds_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bds_pkg::CFG_IDX_W-1:0]  index;
	logic [bds_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/box_downsample_2x2_rgb_unit.sv
// 2x2 box filter downsampler for 8-bit rgb pixels in raster order
// depends on bds_pkg, the three channel interfaces, bds_ram, bds_cfg_regs, bds_scan, bds_avg_out
//
// usage:
//   pix_in  - valid/ready input pixels, x fastest; one transfer per clock unless pix_out stalls
//   pix_out - valid/ready averaged pixels, one for every 2x2 block, frame_end on the last
//   cfg     - register writes (index 0 image_width, index 1 image_height), always ready;
//             write only while no pixel is in flight
// an output is made on the second pixel of each pair in an odd row; the odd last column
// and the odd last row are dropped. the first pixel of a pair is held in a register and
// pair sums of even rows go to a 512 x 27 line store (one write or one read per pixel pair).
// a producing pixel passes the stage 1 register, then the output register, to pix_out.
// throughput: one pixel per clock while pix_out does not stall.
// when pix_out stalls, the output register and one stage behind it fill, then pix_in.ready
// drops; nothing is lost or repeated.
// reset: counters, held pixel and valids clear, geometry returns to 640 x 480; the line
// store is not cleared, each entry is written on an even row before it is read.

module box_downsample_2x2_rgb_unit (
	input  logic           clk,
	input  logic           arst_n,
	bds_pix_in_if.sink     pix_in,
	bds_pix_out_if.source  pix_out,
	bds_cfg_if.sink        cfg
);

	bds_pkg::geom_t                 geom;
	bds_pkg::step_t                 step;
	bds_pkg::pair_t                 line_pair;
	logic [bds_pkg::PAIR_BITS-1:0]  line_rdata;
	logic                           in_ready;
	logic                           accept;
	logic                           line_we;
	logic                           line_re;
	logic [bds_pkg::SLOT_W-1:0]     line_addr;

	assign pix_in.ready = in_ready;
	assign accept       = pix_in.valid & in_ready;
	assign line_pair    = bds_pkg::pair_t'(line_rdata);

	bds_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.geom   (geom)
	);

	bds_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.red       (pix_in.red_in),
		.green     (pix_in.green_in),
		.blue      (pix_in.blue_in),
		.geom      (geom),
		.step      (step),
		.line_we   (line_we),
		.line_re   (line_re),
		.line_addr (line_addr)
	);

	bds_ram #(
		.WIDTH (bds_pkg::PAIR_BITS),
		.DEPTH (bds_pkg::LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_addr),
		.wdata (step.pair),
		.re    (line_re),
		.raddr (line_addr),
		.rdata (line_rdata)
	);

	bds_avg_out u_avg_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.step      (step),
		.line_pair (line_pair),
		.in_ready  (in_ready),
		.pix_out   (pix_out)
	);

endmodule

FILE: hw/rtl/bds_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module bds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/bds_cfg_regs.sv
// configuration registers; stores the clamped frame geometry at write time
// depends on bds_pkg, bds_cfg_if

module bds_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	bds_cfg_if.sink        cfg,
	output bds_pkg::geom_t geom
);

	logic [bds_pkg::WIDTH_W-1:0]  w_raw;
	logic [bds_pkg::WIDTH_W-1:0]  w_eff;
	logic [bds_pkg::HEIGHT_W-1:0] h_raw;
	logic [bds_pkg::HEIGHT_W-1:0] h_eff;
	logic [bds_pkg::WIDTH_W-1:0]  w_even;
	logic [bds_pkg::HEIGHT_W-1:0] h_even;
	bds_pkg::geom_t               geom_q;

	assign cfg.ready = 1'b1;

	always_comb begin
		w_raw = cfg.data[bds_pkg::WIDTH_W-1:0];
		h_raw = cfg.data[bds_pkg::HEIGHT_W-1:0];
		if (w_raw < bds_pkg::WIDTH_W'(2)) begin
			w_eff = bds_pkg::WIDTH_W'(2);
		end else if (w_raw > bds_pkg::WIDTH_W'(bds_pkg::MAX_WIDTH)) begin
			w_eff = bds_pkg::WIDTH_W'(bds_pkg::MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw < bds_pkg::HEIGHT_W'(2)) begin
			h_eff = bds_pkg::HEIGHT_W'(2);
		end else begin
			h_eff = h_raw;
		end
		w_even = {w_eff[bds_pkg::WIDTH_W-1:1], 1'b0};
		h_even = {h_eff[bds_pkg::HEIGHT_W-1:1], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.col_wrap <= bds_pkg::COL_W'(bds_pkg::RESET_WIDTH - 1);
			geom_q.row_wrap <= bds_pkg::HEIGHT_W'(bds_pkg::RESET_HEIGHT - 1);
			geom_q.col_last <= bds_pkg::COL_W'((bds_pkg::RESET_WIDTH / 2) * 2 - 1);
			geom_q.row_last <= bds_pkg::HEIGHT_W'((bds_pkg::RESET_HEIGHT / 2) * 2 - 1);
		end else if (cfg.valid) begin
			case (cfg.index)
				bds_pkg::REG_IMAGE_WIDTH: begin
					geom_q.col_wrap <= bds_pkg::COL_W'(w_eff - bds_pkg::WIDTH_W'(1));
					geom_q.col_last <= bds_pkg::COL_W'(w_even - bds_pkg::WIDTH_W'(1));
				end
				bds_pkg::REG_IMAGE_HEIGHT: begin
					geom_q.row_wrap <= h_eff - bds_pkg::HEIGHT_W'(1);
					geom_q.row_last <= h_even - bds_pkg::HEIGHT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign geom = geom_q;

endmodule

FILE: hw/rtl/bds_scan.sv
// raster position counters, held first pixel of a pair, pair sums and line store control
// depends on bds_pkg

module bds_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [bds_pkg::CHAN_W-1:0]  red,
	input  logic [bds_pkg::CHAN_W-1:0]  green,
	input  logic [bds_pkg::CHAN_W-1:0]  blue,
	input  bds_pkg::geom_t              geom,
	output bds_pkg::step_t              step,
	output logic                        line_we,
	output logic                        line_re,
	output logic [bds_pkg::SLOT_W-1:0]  line_addr
);

	logic [bds_pkg::COL_W-1:0]    col_q;
	logic [bds_pkg::HEIGHT_W-1:0] row_q;
	logic [bds_pkg::CHAN_W-1:0]   held_r_q;
	logic [bds_pkg::CHAN_W-1:0]   held_g_q;
	logic [bds_pkg::CHAN_W-1:0]   held_b_q;
	logic                         odd_col;
	logic                         odd_row;

	assign odd_col = col_q[0];
	assign odd_row = row_q[0];

	always_comb begin
		step.pair.r    = {1'b0, held_r_q} + {1'b0, red};
		step.pair.g    = {1'b0, held_g_q} + {1'b0, green};
		step.pair.b    = {1'b0, held_b_q} + {1'b0, blue};
		step.produce   = odd_col & odd_row;
		step.frame_end = (col_q == geom.col_last) && (row_q == geom.row_last);
	end

	// even rows fill the line store, odd rows read it back
	assign line_we   = accept & odd_col & ~odd_row;
	assign line_re   = accept & odd_col & odd_row;
	assign line_addr = col_q[bds_pkg::COL_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			held_r_q <= '0;
			held_g_q <= '0;
			held_b_q <= '0;
		end else if (accept) begin
			if (!odd_col) begin
				held_r_q <= red;
				held_g_q <= green;
				held_b_q <= blue;
			end
			if (col_q >= geom.col_wrap) begin
				col_q <= '0;
				if (row_q >= geom.row_wrap) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + bds_pkg::HEIGHT_W'(1);
				end
			end else begin
				col_q <= col_q + bds_pkg::COL_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/bds_avg_out.sv
// stage 1 register holding the new pair sums, then the 2x2 average into the output register
// depends on bds_pkg, bds_pix_out_if

module bds_avg_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  bds_pkg::step_t         step,
	input  bds_pkg::pair_t         line_pair,
	output logic                   in_ready,
	bds_pix_out_if.source          pix_out
);

	logic                          valid_s1;
	logic                          frame_end_s1;
	bds_pkg::pair_t                pair_s1;
	logic                          valid_q;
	logic [bds_pkg::CHAN_W-1:0]    red_q;
	logic [bds_pkg::CHAN_W-1:0]    green_q;
	logic [bds_pkg::CHAN_W-1:0]    blue_q;
	logic                          frame_end_q;
	logic                          out_free;
	logic [bds_pkg::PAIR_W:0]      sum_r;
	logic [bds_pkg::PAIR_W:0]      sum_g;
	logic [bds_pkg::PAIR_W:0]      sum_b;

	assign out_free = ~valid_q | pix_out.ready;
	// line store data stays put while stage 1 holds, since a read is issued only on its load
	assign in_ready = ~valid_s1 | out_free;

	always_comb begin
		sum_r = {1'b0, line_pair.r} + {1'b0, pair_s1.r};
		sum_g = {1'b0, line_pair.g} + {1'b0, pair_s1.g};
		sum_b = {1'b0, line_pair.b} + {1'b0, pair_s1.b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= accept & step.produce;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && accept && step.produce) begin
			pair_s1      <= step.pair;
			frame_end_s1 <= step.frame_end;
		end
		if (out_free && valid_s1) begin
			red_q       <= sum_r[bds_pkg::PAIR_W:2];
			green_q     <= sum_g[bds_pkg::PAIR_W:2];
			blue_q      <= sum_b[bds_pkg::PAIR_W:2];
			frame_end_q <= frame_end_s1;
		end
	end

	assign pix_out.valid     = valid_q;
	assign pix_out.red_out   = red_q;
	assign pix_out.green_out = green_q;
	assign pix_out.blue_out  = blue_q;
	assign pix_out.frame_end = frame_end_q;

endmodule
